@@ hw/rtl/mskh_pkg.sv @@
// ----------------------------------------------------------------------------
// mskh_pkg
// Shared types and constants for the multi-string key hash block.
// ----------------------------------------------------------------------------
package mskh_pkg;

  localparam int TS_W     = 31;
  localparam int CFG_W    = 31;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_TABLE_SIZE      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHARS_SIGNED    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BIG_ENDIAN_PACK = 2'd2;

  localparam logic [TS_W-1:0] TABLE_SIZE_RESET = 31'd1024;
  localparam logic            CHARS_SIGNED_RESET = 1'b1;
  localparam logic            BIG_ENDIAN_RESET   = 1'b0;

  // sum * (1 + 2^3 + 2^5 + 2^19) as shifts
  localparam int SHIFT_A = 3;
  localparam int SHIFT_B = 5;
  localparam int SHIFT_C = 19;

  localparam int DIV_STEPS = 32;
  localparam int DIV_CNT_W = 5;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ABS,
    ST_DIVIDE,
    ST_HOLD
  } state_t;

  typedef struct packed {
    logic in_ready;
    logic accept;
    logic key_end;
    logic abs_load;
    logic div_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic zero_last;
    logic div_last;
    logic out_full;
  } status_t;

endpackage

@@ hw/rtl/mskh_ctrl.sv @@
// ----------------------------------------------------------------------------
// mskh_ctrl
// Sequencer: key accumulation, magnitude, bit-serial remainder, result hold.
// ----------------------------------------------------------------------------
module mskh_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  input  logic              m_tready,
  input  mskh_pkg::status_t status,
  output mskh_pkg::cmd_t    cmd
);

  mskh_pkg::state_t state;
  mskh_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mskh_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      mskh_pkg::ST_IDLE: begin
        cmd.in_ready = 1'b1;
        cmd.accept   = s_tvalid;
        if (s_tvalid && status.zero_last) begin
          cmd.key_end = 1'b1;
          state_next  = mskh_pkg::ST_ABS;
        end
      end
      mskh_pkg::ST_ABS: begin
        cmd.abs_load = 1'b1;
        state_next   = mskh_pkg::ST_DIVIDE;
      end
      mskh_pkg::ST_DIVIDE: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = mskh_pkg::ST_HOLD;
        end
      end
      mskh_pkg::ST_HOLD: begin
        if (!status.out_full || m_tready) begin
          cmd.out_load = 1'b1;
          state_next   = mskh_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = mskh_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

@@ hw/rtl/mskh_dp.sv @@
// ----------------------------------------------------------------------------
// mskh_dp
// Datapath: config registers, key accumulators, hash word, divider, output.
// ----------------------------------------------------------------------------
module mskh_dp #(
  parameter int MAX_STRINGS = 4
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [mskh_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mskh_pkg::CFG_W-1:0]    cfg_data,
  input  logic [7:0]                    char_byte,
  input  logic                          end_of_key,
  input  mskh_pkg::cmd_t                cmd,
  output mskh_pkg::status_t             status,
  output logic [mskh_pkg::TS_W-1:0]     bucket_index,
  output logic                          too_many_strings,
  output logic                          out_valid,
  input  logic                          out_ready
);

  localparam int CNT_W = $clog2(MAX_STRINGS + 1);
  localparam int IDX_W = (MAX_STRINGS > 1) ? $clog2(MAX_STRINGS) : 1;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_STRINGS);

  logic [mskh_pkg::TS_W-1:0] table_size;
  logic                      chars_signed;
  logic                      big_endian_pack;

  logic [31:0]      char_sum;
  logic [7:0]       string_xor [MAX_STRINGS];
  logic [CNT_W-1:0] strings_done;
  logic             overflow_seen;

  logic [31:0]                 hash;
  logic                        ovf_hold;
  logic [31:0]                 mag;
  logic [mskh_pkg::TS_W-1:0]   rem;
  logic [mskh_pkg::DIV_CNT_W-1:0] div_cnt;

  logic             is_zero;
  logic [31:0]      char_ext;
  logic [CNT_W-1:0] n_final;
  logic             ovf_final;
  logic [31:0]      word;
  logic [31:0]      sum_mul;
  logic [31:0]      hash_next;
  logic [31:0]      rem_sh;
  logic             rem_ge;

  assign is_zero  = (char_byte == 8'd0);
  assign char_ext = (chars_signed && char_byte[7]) ? {24'hFF_FFFF, char_byte}
                                                   : {24'd0, char_byte};

  always_ff @(posedge clk) begin
    if (rst) begin
      table_size      <= mskh_pkg::TABLE_SIZE_RESET;
      chars_signed    <= mskh_pkg::CHARS_SIGNED_RESET;
      big_endian_pack <= mskh_pkg::BIG_ENDIAN_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        mskh_pkg::REG_TABLE_SIZE:      table_size      <= cfg_data;
        mskh_pkg::REG_CHARS_SIGNED:    chars_signed    <= cfg_data[0];
        mskh_pkg::REG_BIG_ENDIAN_PACK: big_endian_pack <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // string count and overflow as they stand after this zero byte
  always_comb begin
    if (strings_done >= CNT_MAX) begin
      n_final   = strings_done;
      ovf_final = 1'b1;
    end else begin
      n_final   = strings_done + CNT_W'(1);
      ovf_final = overflow_seen;
    end
  end

  always_comb begin
    word = '0;
    for (int k = 0; k < MAX_STRINGS; k++) begin
      if (n_final == CNT_W'(1)) begin
        if (k == 0) begin
          word = word | ({24'd0, string_xor[k]} << (big_endian_pack ? 8 : 16));
        end
      end else if (CNT_W'(k) < n_final) begin
        word = word | ({24'd0, string_xor[k]} << (big_endian_pack ? 8 * k : 8 * (3 - k)));
      end
    end
  end

  assign sum_mul   = char_sum + (char_sum << mskh_pkg::SHIFT_A)
                   + (char_sum << mskh_pkg::SHIFT_B) + (char_sum << mskh_pkg::SHIFT_C);
  assign hash_next = word + sum_mul;

  assign status.zero_last = is_zero && end_of_key;
  assign status.div_last  = (div_cnt == mskh_pkg::DIV_CNT_W'(mskh_pkg::DIV_STEPS - 1));
  assign status.out_full  = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      char_sum      <= '0;
      strings_done  <= '0;
      overflow_seen <= 1'b0;
      for (int k = 0; k < MAX_STRINGS; k++) begin
        string_xor[k] <= '0;
      end
    end else if (cmd.accept) begin
      if (!is_zero) begin
        char_sum <= char_sum + char_ext;
        if (strings_done < CNT_MAX) begin
          string_xor[strings_done[IDX_W-1:0]] <=
            string_xor[strings_done[IDX_W-1:0]] ^ char_byte;
        end
      end else if (end_of_key) begin
        char_sum      <= '0;
        strings_done  <= '0;
        overflow_seen <= 1'b0;
        for (int k = 0; k < MAX_STRINGS; k++) begin
          string_xor[k] <= '0;
        end
      end else begin
        strings_done  <= n_final;
        overflow_seen <= ovf_final;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.key_end) begin
      hash     <= hash_next;
      ovf_hold <= ovf_final;
    end
  end

  // restoring remainder, one bit a cycle
  assign rem_sh = {rem, mag[31]};
  assign rem_ge = (rem_sh >= {1'b0, table_size});

  always_ff @(posedge clk) begin
    if (cmd.abs_load) begin
      mag     <= hash[31] ? (32'd0 - hash) : hash;
      rem     <= '0;
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      mag     <= mag << 1;
      rem     <= rem_ge ? mskh_pkg::TS_W'(rem_sh - {1'b0, table_size})
                        : rem_sh[mskh_pkg::TS_W-1:0];
      div_cnt <= div_cnt + mskh_pkg::DIV_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      too_many_strings <= ovf_hold;
      bucket_index     <= (ovf_hold || table_size == '0) ? '0 : rem;
    end
  end

endmodule

@@ hw/rtl/multi_string_key_hash.sv @@
// ----------------------------------------------------------------------------
// multi_string_key_hash
// Hashes a key of one or more zero-terminated strings into a bucket index.
// ----------------------------------------------------------------------------
// usage:
//   slave stream carries one key character per beat in s_tdata; a zero
//   character closes a string and s_tlast on it closes the key
//   a character beat is taken while the block is idle; only the closing zero beat
//   yields a result
//   after the key's last beat the block computes the magnitude, runs a
//   bit-serial remainder unit and then loads the output register once it
//   is free; no input is taken meanwhile
//   the master stream holds the result in an output register; characters of
//   the next key are taken while it waits, a stalled master only holds the
//   block once the next key has finished
//   table_size, chars_signed and big_endian_pack are set by cfg_we writes
//   while the block is idle; the user must keep to this, the block does not enforce it
//   synchronous reset clears the key state and the output valid and loads the
//   register defaults (1024 buckets, signed chars, little-endian packing)
// ----------------------------------------------------------------------------
module multi_string_key_hash #(
  parameter int MAX_STRINGS = 4
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [mskh_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mskh_pkg::CFG_W-1:0]     cfg_data,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [7:0]                     s_tdata,  // char_byte
  input  logic                           s_tlast,  // end_of_key
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [31:0]                    m_tdata,  // bucket_index, zero pad
  output logic [0:0]                     m_tuser   // too_many_strings
);

  mskh_pkg::cmd_t    cmd;
  mskh_pkg::status_t status;

  logic [mskh_pkg::TS_W-1:0] bucket_index;
  logic                      too_many_strings;

  mskh_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .m_tready (m_tready),
    .status   (status),
    .cmd      (cmd)
  );

  mskh_dp #(
    .MAX_STRINGS (MAX_STRINGS)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .char_byte        (s_tdata),
    .end_of_key       (s_tlast),
    .cmd              (cmd),
    .status           (status),
    .bucket_index     (bucket_index),
    .too_many_strings (too_many_strings),
    .out_valid        (m_tvalid),
    .out_ready        (m_tready)
  );

  assign s_tready = cmd.in_ready;
  assign m_tdata  = {1'b0, bucket_index};
  assign m_tuser  = too_many_strings;

`ifndef SYNTHESIS
  a_ovf_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata == 32'd0)
    else $error("overflowed key must give bucket zero");

  a_busy_after_key: assert property (@(posedge clk) disable iff (rst)
    cmd.key_end |=> !s_tready)
    else $error("input taken while hashing");

  a_load_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> m_tvalid)
    else $error("loaded result not presented");
`endif

endmodule

@@ tb/sv/multi_string_key_hash_tb.sv @@
// ----------------------------------------------------------------------------
// multi_string_key_hash_tb
// Self-checking bench for the multi-string key hash block. A short table of
// hand-picked keys covers the corner cases, then random keys run under
// several register settings and handshake pressure patterns. Each bucket
// result is compared against a behavioral hash model kept in the bench or a table value.
// ----------------------------------------------------------------------------
module multi_string_key_hash_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int KEY_STRINGS   = 4;
  localparam int NUM_PHASES    = 8;
  localparam int PHASE_ITEMS   = 141;
  localparam int NUM_DIRECTED  = 22;
  localparam int SETTLE_CYCLES = 40;
  localparam int CYCLE_LIMIT   = 400000;
  localparam logic [31:0] SUM_FACTOR = 32'd524329;

  typedef struct packed {
    logic [mskh_pkg::TS_W-1:0] bucket;
    logic                      too_many;
  } key_hash_t;

  typedef struct packed {
    logic [7:0]                ch;
    logic                      last;
    logic                      known;
    logic [mskh_pkg::TS_W-1:0] bucket;
    logic                      too_many;
  } stim_row_t;

  logic                           clk;
  logic                           rst;
  logic                           cfg_we;
  logic [mskh_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [mskh_pkg::CFG_W-1:0]     cfg_data;
  logic                           s_tvalid;
  logic                           s_tready;
  logic [7:0]                     s_tdata;  // char_byte
  logic                           s_tlast;  // end_of_key
  logic                           m_tvalid;
  logic                           m_tready;
  logic [31:0]                    m_tdata;  // bucket_index, zero pad
  logic [0:0]                     m_tuser;  // too_many_strings

  multi_string_key_hash dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // hash model state and registers
  logic [mskh_pkg::TS_W-1:0] tbl_size;
  logic                      sum_signed;
  logic                      mirror_pack;
  logic [31:0]               key_sum;
  logic [7:0]                key_xor [KEY_STRINGS];
  int unsigned               closed_strings;
  logic                      key_overflow;

  key_hash_t   pending_buckets [$];
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned mismatches;
  int unsigned cycle_count;
  stim_row_t   directed_rows [NUM_DIRECTED];

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("multi_string_key_hash test failed");
      $finish;
    end
  end

  function automatic void clear_key();
    key_sum = '0;
    for (int k = 0; k < KEY_STRINGS; k++) key_xor[k] = '0;
    closed_strings = 0;
    key_overflow = 1'b0;
  endfunction

  function automatic logic [mskh_pkg::TS_W-1:0] bucket_of(int unsigned nstr);
    logic [31:0] word;
    logic [31:0] h;
    logic [31:0] mag;
    logic [31:0] rem;
    int unsigned pos;
    word = '0;
    for (int k = 0; k < KEY_STRINGS; k++) begin
      if ((nstr == 1 && k == 0) || (nstr > 1 && k < nstr)) begin
        pos = (nstr == 1) ? 2 : 3 - k;
        if (mirror_pack) pos = 3 - pos;
        word = word | ({24'd0, key_xor[k]} << (8 * pos));
      end
    end
    h = word + key_sum * SUM_FACTOR;
    if (tbl_size == '0) return '0;
    mag = h[31] ? (32'd0 - h) : h;
    rem = mag % {1'b0, tbl_size};
    return rem[mskh_pkg::TS_W-1:0];
  endfunction

  // advance the model by one accepted beat
  function automatic bit absorb_char(input logic [7:0] ch, input logic last,
                                     output key_hash_t res);
    logic [31:0] v;
    res = '0;
    if (ch != 8'd0) begin
      v = (sum_signed && ch[7]) ? {24'hFFFFFF, ch} : {24'd0, ch};
      key_sum = key_sum + v;
      if (closed_strings < KEY_STRINGS) key_xor[closed_strings] ^= ch;
      return 1'b0;
    end
    if (closed_strings >= KEY_STRINGS) key_overflow = 1'b1;
    else closed_strings++;
    if (!last) return 1'b0;
    if (key_overflow) begin
      res.too_many = 1'b1;
    end else begin
      res.bucket = bucket_of(closed_strings);
    end
    clear_key();
    return 1'b1;
  endfunction

  // drive one beat and update the expected results once it is taken
  task automatic send_beat(input logic [7:0] ch, input logic last, input bit known,
                           input key_hash_t typed);
    key_hash_t res;
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= ch;
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    if (absorb_char(ch, last, res)) pending_buckets.push_back(known ? typed : res);
  endtask

  task automatic send_random_key(inout int unsigned sent);
    int unsigned roll;
    int unsigned nstr;
    int unsigned len;
    logic [7:0]  ch;
    roll = $urandom_range(99);
    if (roll < 8) nstr = $urandom_range(7, 5);
    else if (roll < 30) nstr = 1;
    else nstr = $urandom_range(4, 2);
    for (int s = 0; s < nstr; s++) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(12) : $urandom_range(5);
      for (int c = 0; c < len; c++) begin
        ch = 8'($urandom_range(255, 1));
        send_beat(ch, $urandom_range(9) == 0, 1'b0, '0);
        sent++;
      end
      send_beat(8'd0, s == nstr - 1, 1'b0, '0);
      sent++;
    end
  endtask

  task automatic set_config(input logic [mskh_pkg::TS_W-1:0] ts, input logic cs,
                            input logic be);
    cfg_we    <= 1'b1;
    cfg_index <= mskh_pkg::REG_TABLE_SIZE;
    cfg_data  <= ts;
    @(posedge clk);
    cfg_index <= mskh_pkg::REG_CHARS_SIGNED;
    cfg_data  <= {{(mskh_pkg::CFG_W-1){1'b0}}, cs};
    @(posedge clk);
    cfg_index <= mskh_pkg::REG_BIG_ENDIAN_PACK;
    cfg_data  <= {{(mskh_pkg::CFG_W-1){1'b0}}, be};
    @(posedge clk);
    cfg_we <= 1'b0;
    tbl_size    = ts;
    sum_signed  = cs;
    mirror_pack = be;
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_buckets.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // result beats
  always @(posedge clk) begin
    key_hash_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_buckets.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat: bucket %0d too_many %0b",
                   m_tdata[mskh_pkg::TS_W-1:0], m_tuser[0]);
      end else begin
        want = pending_buckets.pop_front();
        if (m_tdata[mskh_pkg::TS_W-1:0] !== want.bucket ||
            m_tuser[0] !== want.too_many) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: bucket exp %0d got %0d, too_many exp %0b got %0b",
                     want.bucket, m_tdata[mskh_pkg::TS_W-1:0], want.too_many,
                     m_tuser[0]);
        end
      end
    end
    m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  initial begin
    logic [mskh_pkg::TS_W-1:0] ph_size [NUM_PHASES];
    logic                      ph_signed [NUM_PHASES];
    logic                      ph_mirror [NUM_PHASES];
    int unsigned               sent;

    cycle_count    = 0;
    mismatches     = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    rst       <= 1'b1;
    cfg_we    <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    s_tlast   <= 1'b0;
    m_tready  <= 1'b0;

    tbl_size    = mskh_pkg::TABLE_SIZE_RESET;
    sum_signed  = mskh_pkg::CHARS_SIGNED_RESET;
    mirror_pack = mskh_pkg::BIG_ENDIAN_RESET;
    clear_key();

    // ch, last, known, bucket, too_many
    directed_rows = '{
      // empty single string
      '{8'h00, 1'b1, 1'b1, 31'd0, 1'b0},
      // end flag on characters is ignored
      '{8'hFF, 1'b1, 1'b0, 31'd0, 1'b0},
      '{8'h80, 1'b0, 1'b0, 31'd0, 1'b0},
      '{8'h01, 1'b0, 1'b0, 31'd0, 1'b0},
      '{8'h00, 1'b1, 1'b0, 31'd0, 1'b0},
      // too many strings
      '{8'h00, 1'b0, 1'b0, 31'd0, 1'b0},
      '{8'h00, 1'b0, 1'b0, 31'd0, 1'b0},
      '{8'h00, 1'b0, 1'b0, 31'd0, 1'b0},
      '{8'h00, 1'b0, 1'b0, 31'd0, 1'b0},
      '{8'h55, 1'b0, 1'b0, 31'd0, 1'b0},
      '{8'h00, 1'b1, 1'b1, 31'd0, 1'b1},
      // four strings summing to -1, hash lands on the most negative value
      '{8'h80, 1'b0, 1'b0, 31'd0, 1'b0},
      '{8'h00, 1'b0, 1'b0, 31'd0, 1'b0},
      '{8'h08, 1'b0, 1'b0, 31'd0, 1'b0},
      '{8'h00, 1'b0, 1'b0, 31'd0, 1'b0},
      '{8'h27, 1'b0, 1'b0, 31'd0, 1'b0},
      '{8'h27, 1'b0, 1'b0, 31'd0, 1'b0},
      '{8'h00, 1'b0, 1'b0, 31'd0, 1'b0},
      '{8'h29, 1'b0, 1'b0, 31'd0, 1'b0},
      '{8'h00, 1'b1, 1'b0, 31'd0, 1'b0},
      '{8'h7F, 1'b0, 1'b0, 31'd0, 1'b0},
      '{8'h00, 1'b1, 1'b0, 31'd0, 1'b0}
    };

    ph_size   = '{31'h7FFFFFFF, 31'd1, 31'd0, 31'd0, 31'd1024, 31'd0, 31'd0, 31'h7FFFFFFF};
    ph_signed = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1};
    ph_mirror = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
    ph_size[3]   = mskh_pkg::TS_W'($urandom_range(32'h7FFFFFFF, 1));
    ph_signed[3] = 1'($urandom_range(1));
    ph_mirror[3] = 1'($urandom_range(1));
    ph_size[5]   = mskh_pkg::TS_W'($urandom_range(64, 2));
    ph_size[6]   = mskh_pkg::TS_W'($urandom_range(32'h7FFFFFFF, 32'h40000000));
    ph_signed[6] = 1'($urandom_range(1));

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i])
      send_beat(directed_rows[i].ch, directed_rows[i].last, directed_rows[i].known,
                key_hash_t'{directed_rows[i].bucket, directed_rows[i].too_many});
    drain();

    // the most negative hash again, now against the largest table
    set_config(31'h7FFFFFFF, 1'b1, 1'b0);
    for (int i = 11; i < 20; i++)
      send_beat(directed_rows[i].ch, directed_rows[i].last, 1'b0, '0);
    drain();

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 83; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 83; end
        default: begin send_idle_pct = 17; recv_stall_pct = 17; end
      endcase
      set_config(ph_size[p], ph_signed[p], ph_mirror[p]);
      sent = 0;
      while (sent < PHASE_ITEMS) send_random_key(sent);
      drain();
    end

    if (mismatches == 0) begin
      $display("multi_string_key_hash test passed");
    end else begin
      $display("multi_string_key_hash test failed");
    end
    $finish;
  end

endmodule
